// ===== rtl/core/psu_pkg.sv =====
// ============================================================================
// psu_pkg - PNG scanline unfilter shared definitions
// Types, register map and defaults used by the unfilter front end, queue,
// back end and top level.
// ============================================================================
package psu_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned BppW      = 4;
  localparam int unsigned ColW      = 14;
  localparam int unsigned RowW      = 16;
  localparam int unsigned PAddrW    = 4;
  localparam int unsigned PDataW    = 32;
  localparam int unsigned QueueDepth = 4;

  localparam int unsigned DefMaxRowBytes   = 8192;
  localparam int unsigned DefMaxPixelBytes = 8;

  localparam logic [BppW-1:0] RstBpp      = 4'd4;
  localparam logic [ColW-1:0] RstRowBytes = 14'd4;
  localparam logic [RowW-1:0] RstRowCount = 16'd1;

  // register index = paddr[3:2]
  localparam logic [1:0] RegBpp      = 2'd0;
  localparam logic [1:0] RegRowBytes = 2'd1;
  localparam logic [1:0] RegRowCount = 2'd2;

  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } psu_filter_e;

  localparam logic [ByteW-1:0] FiltMaxCode = 8'd4;

  typedef struct packed {
    logic [BppW-1:0] bpp;
    logic [ColW-1:0] row_bytes;
    logic [RowW-1:0] row_count;
  } psu_cfg_t;

  // one classified data byte, front end to back end
  typedef struct packed {
    logic [ByteW-1:0] data;
    logic [ColW-1:0]  col;
    psu_filter_e      filt;
    logic             first_row;
    logic             row_end;
    logic             image_end;
    logic             bad;
  } psu_entry_t;

endpackage

// ===== rtl/core/psu_ifs.sv =====
// ============================================================================
// psu_ifs - PNG scanline unfilter stream interfaces
// Valid/ready channels for filtered input bytes and reconstructed bytes.
// ============================================================================
interface psu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] filtered_byte;

  modport source (output valid, output filtered_byte, input ready);
  modport sink   (input valid, input filtered_byte, output ready);
endinterface

interface psu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] recon_byte;
  logic       row_end;
  logic       image_end;
  logic       bad_filter;

  modport source (output valid, output recon_byte, output row_end,
                  output image_end, output bad_filter, input ready);
  modport sink   (input valid, input recon_byte, input row_end,
                  input image_end, input bad_filter, output ready);
endinterface

// ===== rtl/core/png_scanline_unfilter.sv =====
// ============================================================================
// png_scanline_unfilter - PNG row filter reconstruction
// Reverses None/Sub/Up/Average/Paeth row filtering on an inflated byte stream.
// ============================================================================
//
//  channel  dir  handshake      beat payload
//  -------  ---  -------------  ------------------------------------------
//  in_bus   in   valid/ready    filtered_byte (filter type or data byte)
//  out_bus  out  valid/ready    recon_byte, row_end, image_end, bad_filter
//  apb      in   psel/penable   register write/read, pready tied high
//
//  One beat per clock in steady state while out_bus is ready. A data byte
//  passes the queue, execute and output registers; filter-type beats
//  give no result. The loop set by the combinational predictor and the
//  line buffer read/write port in the execute stage fixes the rate at 1.
//  Reset clears control only; the line buffer has no clearing pass, rows
//  after the first read it only where it was written by the previous row.
//  A stall on out_bus fills the 4-beat queue, then drops in_bus.ready.
//
module png_scanline_unfilter #(
  parameter int unsigned MAX_ROW_BYTES   = psu_pkg::DefMaxRowBytes,
  parameter int unsigned MAX_PIXEL_BYTES = psu_pkg::DefMaxPixelBytes
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  psu_in_if.sink                      in_bus,
  psu_out_if.source                   out_bus,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [psu_pkg::PAddrW-1:0]  paddr,
  input  logic [psu_pkg::PDataW-1:0]  pwdata,
  output logic [psu_pkg::PDataW-1:0]  prdata,
  output logic                        pready
);

  psu_pkg::psu_cfg_t   cfg_q;
  logic                cfg_wr;
  logic [1:0]          reg_idx;

  logic                q_push, q_full, q_pop, q_valid;
  psu_pkg::psu_entry_t q_in, q_out;

  // --- configuration registers ---------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bpp       <= psu_pkg::RstBpp;
      cfg_q.row_bytes <= psu_pkg::RstRowBytes;
      cfg_q.row_count <= psu_pkg::RstRowCount;
    end else if (cfg_wr) begin
      case (reg_idx)
        psu_pkg::RegBpp:      cfg_q.bpp       <= pwdata[psu_pkg::BppW-1:0];
        psu_pkg::RegRowBytes: cfg_q.row_bytes <= pwdata[psu_pkg::ColW-1:0];
        psu_pkg::RegRowCount: cfg_q.row_count <= pwdata[psu_pkg::RowW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      psu_pkg::RegBpp:      prdata = 32'(cfg_q.bpp);
      psu_pkg::RegRowBytes: prdata = 32'(cfg_q.row_bytes);
      psu_pkg::RegRowCount: prdata = 32'(cfg_q.row_count);
      default:              prdata = '0;
    endcase
  end

  // --- front end: filter bytes, column/row tracking -------------------------
  psu_front #(
    .MAX_ROW_BYTES (MAX_ROW_BYTES)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .in_bus  (in_bus),
    .full_i  (q_full),
    .push_o  (q_push),
    .entry_o (q_in)
  );

  // --- decoupling queue ------------------------------------------------------
  psu_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .entry_o (q_out)
  );

  // --- back end: line buffer, predictor, output register --------------------
  psu_back #(
    .MAX_ROW_BYTES   (MAX_ROW_BYTES),
    .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_valid_i (q_valid),
    .q_entry_i (q_out),
    .q_pop_o   (q_pop),
    .out_bus   (out_bus)
  );

endmodule

// ===== rtl/core/psu_queue.sv =====
// ============================================================================
// psu_queue - classified byte queue
// Small FIFO between the unfilter front end and back end.
// ============================================================================
module psu_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  psu_pkg::psu_entry_t entry_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output psu_pkg::psu_entry_t entry_o
);

  localparam int unsigned Depth = psu_pkg::QueueDepth;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  psu_pkg::psu_entry_t slots_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign entry_o = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) slots_q[wr_ptr_q] <= entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      if (push_i && !pop_i)      count_q <= count_q + 1'b1;
      else if (pop_i && !push_i) count_q <= count_q - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("push into full queue");

endmodule

// ===== rtl/core/psu_front.sv =====
// ============================================================================
// psu_front - unfilter front end
// Accepts stream bytes, takes filter-type bytes, tags data bytes with column,
// filter, first-row, bad and row/image end flags, pushes them to the queue.
// ============================================================================
module psu_front #(
  parameter int unsigned MAX_ROW_BYTES = psu_pkg::DefMaxRowBytes
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  psu_pkg::psu_cfg_t   cfg_i,
  psu_in_if.sink              in_bus,
  input  logic                full_i,
  output logic                push_o,
  output psu_pkg::psu_entry_t entry_o
);

  logic                         await_q;
  logic [psu_pkg::ColW-1:0]     col_q;
  logic [psu_pkg::RowW-1:0]     row_q;
  psu_pkg::psu_filter_e         filt_q;
  logic                         bad_q;

  logic        accept;
  logic        is_bad;
  logic        rend, iend;
  logic [31:0] rb_eff, rc_eff;

  assign in_bus.ready = !full_i;
  assign accept       = in_bus.valid && !full_i;

  always_comb begin
    if (cfg_i.row_bytes == '0)                            rb_eff = 32'd1;
    else if (32'(cfg_i.row_bytes) > 32'(MAX_ROW_BYTES))   rb_eff = 32'(MAX_ROW_BYTES);
    else                                                  rb_eff = 32'(cfg_i.row_bytes);
    rc_eff = (cfg_i.row_count == '0) ? 32'd1 : 32'(cfg_i.row_count);
  end

  assign is_bad = in_bus.filtered_byte > psu_pkg::FiltMaxCode;
  assign rend   = (32'(col_q) + 32'd1) >= rb_eff;
  assign iend   = rend && ((32'(row_q) + 32'd1) >= rc_eff);

  assign push_o = accept && !await_q;
  always_comb begin
    entry_o.data      = in_bus.filtered_byte;
    entry_o.col       = col_q;
    entry_o.filt      = filt_q;
    entry_o.first_row = (row_q == '0);
    entry_o.row_end   = rend;
    entry_o.image_end = iend;
    entry_o.bad       = bad_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      await_q <= 1'b1;
      col_q   <= '0;
      row_q   <= '0;
      filt_q  <= psu_pkg::FILT_NONE;
      bad_q   <= 1'b0;
    end else if (accept) begin
      if (await_q) begin
        bad_q   <= is_bad;
        filt_q  <= is_bad ? psu_pkg::FILT_NONE
                          : psu_pkg::psu_filter_e'(in_bus.filtered_byte[2:0]);
        col_q   <= '0;
        await_q <= 1'b0;
      end else if (rend) begin
        col_q   <= '0;
        await_q <= 1'b1;
        row_q   <= iend ? '0 : row_q + 1'b1;
      end else begin
        col_q   <= col_q + 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/psu_back.sv =====
// ============================================================================
// psu_back - unfilter back end
// Upper-row line buffer, neighbor history, predictor and output register.
// ============================================================================
module psu_back #(
  parameter int unsigned MAX_ROW_BYTES   = psu_pkg::DefMaxRowBytes,
  parameter int unsigned MAX_PIXEL_BYTES = psu_pkg::DefMaxPixelBytes
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  psu_pkg::psu_cfg_t   cfg_i,
  input  logic                q_valid_i,
  input  psu_pkg::psu_entry_t q_entry_i,
  output logic                q_pop_o,
  psu_out_if.source           out_bus
);

  localparam int unsigned AW = $clog2(MAX_ROW_BYTES);
  localparam int unsigned HW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

  logic [7:0] line_mem [MAX_ROW_BYTES];
  logic [7:0] rdata_q;
  logic [7:0] byp_q;
  logic       byp_valid_q;

  logic                e_valid_q;
  psu_pkg::psu_entry_t e_q;
  logic [7:0] hist_a_q [MAX_PIXEL_BYTES];
  logic [7:0] hist_c_q [MAX_PIXEL_BYTES];

  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       out_rend_q, out_iend_q, out_bad_q;

  logic          e_fire;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [31:0]   rd_ext, wr_ext;
  logic [3:0]    bpp_eff;
  logic [HW-1:0] hidx;
  logic [7:0]    a, b, c, pred, recon;
  logic [8:0]    ab_sum;
  logic signed [10:0] pa, pb, pc, da, db, dc;

  assign e_fire  = e_valid_q && (!out_valid_q || out_bus.ready);
  assign q_pop_o = q_valid_i && (!e_valid_q || e_fire);

  // column clamps to the last buffer entry
  always_comb begin
    rd_ext  = 32'(q_entry_i.col);
    wr_ext  = 32'(e_q.col);
    rd_addr = (rd_ext >= 32'(MAX_ROW_BYTES)) ? AW'(MAX_ROW_BYTES - 1) : rd_ext[AW-1:0];
    wr_addr = (wr_ext >= 32'(MAX_ROW_BYTES)) ? AW'(MAX_ROW_BYTES - 1) : wr_ext[AW-1:0];
  end

  always_comb begin
    if (cfg_i.bpp == '0)                              bpp_eff = 4'd1;
    else if (32'(cfg_i.bpp) > 32'(MAX_PIXEL_BYTES))   bpp_eff = 4'(MAX_PIXEL_BYTES);
    else                                              bpp_eff = cfg_i.bpp;
    hidx = HW'(bpp_eff - 4'd1);
  end

  // neighbors left of the row start are zero
  always_comb begin
    b = e_q.first_row ? 8'd0 : (byp_valid_q ? byp_q : rdata_q);
    if (32'(e_q.col) < 32'(bpp_eff)) begin
      a = 8'd0;
      c = 8'd0;
    end else begin
      a = hist_a_q[hidx];
      c = hist_c_q[hidx];
    end
  end

  always_comb begin
    ab_sum = {1'b0, a} + {1'b0, b};
    da = 11'(signed'({3'b0, b})) - 11'(signed'({3'b0, c}));
    db = 11'(signed'({3'b0, a})) - 11'(signed'({3'b0, c}));
    dc = 11'(signed'({2'b0, ab_sum})) - 11'(signed'({2'b0, c, 1'b0}));
    pa = (da < 0) ? -da : da;
    pb = (db < 0) ? -db : db;
    pc = (dc < 0) ? -dc : dc;
    case (e_q.filt)
      psu_pkg::FILT_SUB:   pred = a;
      psu_pkg::FILT_UP:    pred = b;
      psu_pkg::FILT_AVG:   pred = ab_sum[8:1];
      psu_pkg::FILT_PAETH: begin
        if (pa <= pb && pa <= pc) pred = a;
        else if (pb <= pc)        pred = b;
        else                      pred = c;
      end
      default:             pred = 8'd0;
    endcase
    recon = e_q.data + pred;
  end

  // line buffer: write retiring byte, registered read of the next one
  always_ff @(posedge clk_i) begin
    if (e_fire) line_mem[wr_addr] <= recon;
    if (q_pop_o) rdata_q <= line_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      e_q   <= q_entry_i;
      byp_q <= recon;
    end
    if (e_fire) begin
      hist_a_q[0] <= recon;
      hist_c_q[0] <= b;
      for (int k = 1; k < int'(MAX_PIXEL_BYTES); k++) begin
        hist_a_q[k] <= hist_a_q[k-1];
        hist_c_q[k] <= hist_c_q[k-1];
      end
      out_byte_q <= recon;
      out_rend_q <= e_q.row_end;
      out_iend_q <= e_q.image_end;
      out_bad_q  <= e_q.bad;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q   <= 1'b0;
      byp_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        e_valid_q   <= 1'b1;
        byp_valid_q <= e_fire && (wr_addr == rd_addr);
      end else if (e_fire) begin
        e_valid_q   <= 1'b0;
        byp_valid_q <= 1'b0;
      end
      if (e_fire)             out_valid_q <= 1'b1;
      else if (out_bus.ready) out_valid_q <= 1'b0;
    end
  end

  assign out_bus.valid      = out_valid_q;
  assign out_bus.recon_byte = out_byte_q;
  assign out_bus.row_end    = out_rend_q;
  assign out_bus.image_end  = out_iend_q;
  assign out_bus.bad_filter = out_bad_q;

  a_byp_needs_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byp_valid_q |-> e_valid_q)
    else $error("bypass valid without entry in execute");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (e_valid_q && !e_fire) |=> (e_valid_q && $stable(e_q)))
    else $error("execute entry changed while stalled");

  a_image_end_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_iend_q) |-> out_rend_q)
    else $error("image end without row end");

endmodule

// ===== sim/psu_recon_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// psu_recon_checker - scoreboard for the PNG scanline unfilter
// Watches the byte streams and the register port, rebuilds every row the same
// way the block should, and compares each output beat with the oldest
// expected one.
// ----------------------------------------------------------------------------
module psu_recon_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  psu_in_if                          in_mon,
  psu_out_if                         out_mon,
  input  logic                       psel_i,
  input  logic                       penable_i,
  input  logic                       pwrite_i,
  input  logic                       pready_i,
  input  logic [psu_pkg::PAddrW-1:0] paddr_i,
  input  logic [psu_pkg::PDataW-1:0] pwdata_i,
  output int                         fail_count_o,
  output int                         pending_o,
  output int                         results_o
);

  localparam int RowMax     = psu_pkg::DefMaxRowBytes;
  localparam int PixMax     = psu_pkg::DefMaxPixelBytes;
  localparam int MaxReports = 10;

  typedef struct packed {
    logic [psu_pkg::ByteW-1:0] recon;
    logic                      row_end;
    logic                      image_end;
    logic                      bad_filter;
  } recon_beat_t;

  logic [psu_pkg::ByteW-1:0] upper_row [RowMax];
  logic [psu_pkg::ByteW-1:0] left_px   [PixMax];
  logic [psu_pkg::ByteW-1:0] upleft_px [PixMax];
  psu_pkg::psu_filter_e      row_filt;
  logic [psu_pkg::ColW-1:0]  col_idx;
  logic [psu_pkg::RowW-1:0]  row_idx;
  logic                      want_filter;
  logic                      row_bad;

  logic [psu_pkg::BppW-1:0]  cfg_bpp;
  logic [psu_pkg::ColW-1:0]  cfg_row_bytes;
  logic [psu_pkg::RowW-1:0]  cfg_row_count;

  recon_beat_t      expected_beats [$];
  int               mismatches;
  int               results;
  int               pending;

  assign fail_count_o = mismatches;
  assign pending_o    = pending;
  assign results_o    = results;

  // one stream byte: a filter type opens a row, a data byte yields a beat
  task automatic reconstruct_byte(input logic [psu_pkg::ByteW-1:0] x);
    int          bpp, rb, rc, col;
    int          a, b, c, pred, pa, pb, pc;
    logic [7:0]  recon;
    recon_beat_t beat;
    bpp = (cfg_bpp == 0) ? 1 : ((cfg_bpp > PixMax) ? PixMax : int'(cfg_bpp));
    rb  = (cfg_row_bytes == 0) ? 1 :
          ((cfg_row_bytes > RowMax) ? RowMax : int'(cfg_row_bytes));
    rc  = (cfg_row_count == 0) ? 1 : int'(cfg_row_count);
    if (want_filter) begin
      row_bad  = (x > psu_pkg::FiltMaxCode);
      row_filt = row_bad ? psu_pkg::FILT_NONE : psu_pkg::psu_filter_e'(x[2:0]);
      for (int k = 0; k < PixMax; k++) begin
        left_px[k]   = '0;
        upleft_px[k] = '0;
      end
      col_idx     = '0;
      want_filter = 1'b0;
    end else begin
      col = (int'(col_idx) >= RowMax) ? RowMax - 1 : int'(col_idx);
      a   = left_px[bpp-1];
      c   = upleft_px[bpp-1];
      b   = (row_idx == 0) ? 0 : int'(upper_row[col]);
      case (row_filt)
        psu_pkg::FILT_SUB:   pred = a;
        psu_pkg::FILT_UP:    pred = b;
        psu_pkg::FILT_AVG:   pred = (a + b) >> 1;
        psu_pkg::FILT_PAETH: begin
          pa = (b > c) ? b - c : c - b;
          pb = (a > c) ? a - c : c - a;
          pc = (a + b > 2 * c) ? a + b - 2 * c : 2 * c - a - b;
          if (pa <= pb && pa <= pc) pred = a;
          else if (pb <= pc)        pred = b;
          else                      pred = c;
        end
        default:             pred = 0;
      endcase
      recon = 8'(int'(x) + pred);
      for (int k = PixMax - 1; k > 0; k--) begin
        left_px[k]   = left_px[k-1];
        upleft_px[k] = upleft_px[k-1];
      end
      left_px[0]     = recon;
      upleft_px[0]   = 8'(b);
      upper_row[col] = recon;

      beat.recon      = recon;
      beat.row_end    = (int'(col_idx) + 1 >= rb);
      beat.image_end  = beat.row_end && (int'(row_idx) + 1 >= rc);
      beat.bad_filter = row_bad;
      expected_beats.push_back(beat);

      if (beat.row_end) begin
        col_idx     = '0;
        want_filter = 1'b1;
        row_idx     = beat.image_end ? '0 : row_idx + 1'b1;
      end else begin
        col_idx = col_idx + 1'b1;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    recon_beat_t got, exp_beat;
    if (!rst_ni) begin
      cfg_bpp       = psu_pkg::RstBpp;
      cfg_row_bytes = psu_pkg::RstRowBytes;
      cfg_row_count = psu_pkg::RstRowCount;
      for (int k = 0; k < RowMax; k++) upper_row[k] = '0;
      for (int k = 0; k < PixMax; k++) begin
        left_px[k]   = '0;
        upleft_px[k] = '0;
      end
      row_filt    = psu_pkg::FILT_NONE;
      col_idx     = '0;
      row_idx     = '0;
      want_filter = 1'b1;
      row_bad     = 1'b0;
      expected_beats.delete();
      mismatches  = 0;
      results     = 0;
      pending     = 0;
    end else begin
      // register writes land first, they never share an edge with stream beats
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[3:2])
          psu_pkg::RegBpp:      cfg_bpp       = pwdata_i[psu_pkg::BppW-1:0];
          psu_pkg::RegRowBytes: cfg_row_bytes = pwdata_i[psu_pkg::ColW-1:0];
          psu_pkg::RegRowCount: cfg_row_count = pwdata_i[psu_pkg::RowW-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) reconstruct_byte(in_mon.filtered_byte);
      if (out_mon.valid && out_mon.ready) begin
        results++;
        got = '{out_mon.recon_byte, out_mon.row_end, out_mon.image_end,
                out_mon.bad_filter};
        if (expected_beats.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("%0t: unexpected beat recon=%h row_end=%b image_end=%b bad=%b",
                     $realtime, got.recon, got.row_end, got.image_end, got.bad_filter);
        end else begin
          exp_beat = expected_beats.pop_front();
          if (got.recon !== exp_beat.recon || got.row_end !== exp_beat.row_end ||
              got.image_end !== exp_beat.image_end ||
              got.bad_filter !== exp_beat.bad_filter) begin
            mismatches++;
            if (mismatches <= MaxReports)
              $display({"%0t: beat %0d exp recon=%h re=%b ie=%b bad=%b,",
                        " got recon=%h re=%b ie=%b bad=%b"},
                       $realtime, results, exp_beat.recon, exp_beat.row_end,
                       exp_beat.image_end, exp_beat.bad_filter, got.recon,
                       got.row_end, got.image_end, got.bad_filter);
          end
        end
      end
      pending = expected_beats.size();
    end
  end

endmodule

// ===== sim/tb_png_scanline_unfilter.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_png_scanline_unfilter - stream test of the PNG scanline unfilter
// Feeds filtered rows under a sequence of register settings (clipped pixel
// size, zero sizes, a row count changed mid-image), with random gaps on both
// streams and one long output stall. The checker beside the block predicts
// and compares every reconstructed beat.
// ----------------------------------------------------------------------------
module tb_png_scanline_unfilter;

  localparam int WatchdogLimit  = 2000;
  localparam int DrainCycles    = 8;     // settle margin once every expected beat is out
  localparam int LongHoldCycles = 120;   // well past the 4-beat queue
  localparam logic [7:0] BadFiltLow = psu_pkg::FiltMaxCode + 8'd1;
  localparam logic [7:0] BadFiltTop = 8'hFF;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       psel, penable, pwrite, pready;
  logic [psu_pkg::PAddrW-1:0] paddr;
  logic [psu_pkg::PDataW-1:0] pwdata, prdata;

  int fail_count, pending, results;
  int beats_sent, settings_run, quiet_cycles;
  bit idle_on, hold_req;

  psu_in_if  in_ch ();
  psu_out_if out_ch ();

  png_scanline_unfilter u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_bus  (in_ch),
    .out_bus (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  psu_recon_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .results_o    (results)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // any beat on either stream resets the quiet counter
  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("%0t: no beat for %0d cycles", $realtime, quiet_cycles);
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // output side: random stall bursts, plus one long hold-off on request
  initial begin : sink_side
    int stall_left;
    bit hold_done;
    stall_left = 0;
    hold_done  = 1'b0;
    out_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        stall_left = LongHoldCycles;
        hold_done  = 1'b1;
      end else if (stall_left == 0 && idle_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 12);
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // one input beat; valid stays up across back-to-back beats
  task automatic send_byte(input logic [7:0] b);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_ch.valid         <= 1'b1;
    in_ch.filtered_byte <= b;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    beats_sent++;
  endtask

  // filter byte, mostly legal, then random data with extra weight on 00/FF
  task automatic send_row(input int len);
    int r;
    r = $urandom_range(0, 9);
    send_byte((r < 9) ? 8'($urandom_range(0, 4)) : 8'($urandom_range(BadFiltLow, 255)));
    repeat (len) begin
      r = $urandom_range(0, 7);
      send_byte((r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom_range(0, 255)));
    end
  endtask

  // stop offering, then wait until every expected beat is out and the pipe
  // has settled
  task automatic drain;
    in_ch.valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [psu_pkg::PDataW-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // upper bits are random junk; the block keeps only the field width
  task automatic program_regs(input logic [3:0] bpp, input logic [13:0] rb,
                              input logic [15:0] rc);
    drain();
    apb_write(psu_pkg::RegBpp,      (32'($urandom()) & ~32'hF)    | 32'(bpp));
    apb_write(psu_pkg::RegRowBytes, (32'($urandom()) & ~32'h3FFF) | 32'(rb));
    apb_write(psu_pkg::RegRowCount, (32'($urandom()) & ~32'hFFFF) | 32'(rc));
    settings_run++;
  endtask

  // whole images only, so row_bytes never grows under a partly built image
  task automatic run_setting(input logic [3:0] bpp, input logic [13:0] rb,
                             input logic [15:0] rc, input int images);
    int rows, len;
    rows = (rc == 0) ? 1 : int'(rc);
    len  = (rb == 0) ? 1 :
           ((rb > psu_pkg::DefMaxRowBytes) ? psu_pkg::DefMaxRowBytes : int'(rb));
    program_regs(bpp, rb, rc);
    repeat (images * rows) send_row(len);
  endtask

  initial begin : stimulus
    logic [7:0] dir_filters [7];
    logic [7:0] dir_data [21];
    in_ch.valid         <= 1'b0;
    in_ch.filtered_byte <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    rst_ni   = 1'b0;
    idle_on  = 1'b1;
    hold_req = 1'b0;
    beats_sent   = 0;
    settings_run = 0;
    dir_filters = '{8'(psu_pkg::FILT_NONE), 8'(psu_pkg::FILT_SUB), 8'(psu_pkg::FILT_UP),
                    8'(psu_pkg::FILT_AVG), 8'(psu_pkg::FILT_PAETH), BadFiltLow, BadFiltTop};
    dir_data = '{8'hFF, 8'h00, 8'h80,   8'h01, 8'hFF, 8'h7F,
                 8'hFF, 8'hFF, 8'h01,   8'h00, 8'hFF, 8'h80,
                 8'h10, 8'hF0, 8'hFF,   8'hAA, 8'h55, 8'h00,
                 8'hFF, 8'hFF, 8'hFF};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: one 7-row image, every filter once, then both bad-code extremes
    program_regs(4'd2, 14'd3, 16'd7);
    for (int r = 0; r < 7; r++) begin
      send_byte(dir_filters[r]);
      for (int k = 0; k < 3; k++) send_byte(dir_data[r*3+k]);
    end

    // zero sizes act as one: single-byte rows, every row its own image
    run_setting(4'd0, 14'd0, 16'd0, 20);
    run_setting(4'd1, 14'd7, 16'd3, 4);
    program_regs(4'd8, 14'd24, 16'd4);
    hold_req = 1'b1;  // sender keeps pushing while the output side holds off
    repeat (2 * 4) send_row(24);
    run_setting(4'd15, 14'd13, 16'd5, 2);   // pixel size clips to 8
    repeat (8)
      run_setting(4'($urandom_range(0, 15)), 14'($urandom_range(1, 40)),
                  16'($urandom_range(1, 6)), 1);

    // last stretch runs at full rate on both sides
    idle_on = 1'b0;

    // max row count, then shrink it and change pixel size mid-image:
    // row 6 becomes the last row of the image
    program_regs(4'd3, 14'd5, 16'hFFFF);
    repeat (6) send_row(5);
    drain();
    apb_write(psu_pkg::RegRowCount, 32'd3);
    apb_write(psu_pkg::RegBpp, 32'd6);
    send_row(5);

    drain();

    $display("Sent %0d stream beats, checked %0d reconstructed bytes across %0d settings",
             beats_sent, results, settings_run);
    $display("Covered all filters, bad codes, clipped sizes, mid-image writes, long stall");
    if (pending != 0) $display("%0d reconstructed bytes never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/psu_pkg.sv
rtl/core/psu_ifs.sv
rtl/core/psu_queue.sv
rtl/core/psu_front.sv
rtl/core/psu_back.sv
rtl/core/png_scanline_unfilter.sv
sim/psu_recon_checker.sv
sim/tb_png_scanline_unfilter.sv
